// File: src/bbcr_pkg.sv
// Shared types and codes for the box-box collision response unit.
// No dependencies.
package bbcr_pkg;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_UP    = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4
   } dir_type;

   localparam int CORNER_BITS = 2;

endpackage

// File: src/bbcr_req_if.sv
// Request channel: one pair of boxes per transfer, valid/ready handshake.
// No dependencies.
interface bbcr_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic [COORD_BITS-2:0]        first_width;
   logic [COORD_BITS-2:0]        first_height;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic [COORD_BITS-2:0]        second_width;
   logic [COORD_BITS-2:0]        second_height;

   modport source (
      output valid, first_x, first_y, first_width, first_height,
             second_x, second_y, second_width, second_height,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, first_width, first_height,
             second_x, second_y, second_width, second_height,
      output ready
   );
endinterface

// File: src/bbcr_rsp_if.sv
// Response channel: collision result per box pair, valid/ready handshake.
// Depends on bbcr_pkg.
interface bbcr_rsp_if
   import bbcr_pkg::*;
#(
   parameter int COORD_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [2:0]             contact_dir;
   logic [CORNER_BITS-1:0] closest_corner;
   logic [COORD_BITS:0]    delta_x;
   logic [COORD_BITS:0]    delta_y;

   modport source (
      output valid, hit, contact_dir, closest_corner, delta_x, delta_y,
      input  ready
   );
   modport sink (
      input  valid, hit, contact_dir, closest_corner, delta_x, delta_y,
      output ready
   );
endinterface

// File: src/bbcr_solver.sv
// Combinational collision math: overlap test, nearest corner, gaps, direction.
// Depends on bbcr_pkg.
module bbcr_solver
   import bbcr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic [COORD_BITS-2:0]        aw,
   input  logic [COORD_BITS-2:0]        ah,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic [COORD_BITS-2:0]        bw,
   input  logic [COORD_BITS-2:0]        bh,
   output logic                         hit,
   output dir_type                      dir,
   output logic [CORNER_BITS-1:0]       corner,
   output logic [COORD_BITS:0]          delta_x,
   output logic [COORD_BITS:0]          delta_y
);
   // headroom for doubled edges and their differences
   localparam int EW = COORD_BITS + 3;

   logic signed [EW-1:0] ax_e, ay_e, aw_e, ah_e, bx_e, by_e, bw_e, bh_e;
   logic signed [EW-1:0] a_r, a_b, b_r, b_b;
   logic signed [EW-1:0] cx2, cy2;
   logic signed [EW-1:0] dl, dr, dt, db;
   logic signed [EW-1:0] adl, adr, adt, adb;
   logic signed [EW-1:0] c1x, c1y, c2x, c2y, gx, gy, agx, agy;
   logic                 right, bottom;

   always_comb begin
      ax_e = EW'(ax);
      ay_e = EW'(ay);
      bx_e = EW'(bx);
      by_e = EW'(by);
      aw_e = EW'({1'b0, aw});
      ah_e = EW'({1'b0, ah});
      bw_e = EW'({1'b0, bw});
      bh_e = EW'({1'b0, bh});

      a_r = ax_e + aw_e;
      a_b = ay_e + ah_e;
      b_r = bx_e + bw_e;
      b_b = by_e + bh_e;

      hit = (ax_e <= b_r) && (bx_e <= a_r) && (ay_e <= b_b) && (by_e <= a_b);

      // center doubled so halving stays exact
      cx2 = (bx_e <<< 1) + bw_e;
      cy2 = (by_e <<< 1) + bh_e;
      dl  = (ax_e <<< 1) - cx2;
      dr  = (a_r <<< 1) - cx2;
      dt  = (ay_e <<< 1) - cy2;
      db  = (a_b <<< 1) - cy2;
      adl = (dl < 0) ? -dl : dl;
      adr = (dr < 0) ? -dr : dr;
      adt = (dt < 0) ? -dt : dt;
      adb = (db < 0) ? -db : db;

      // ties keep the left column / top row
      right  = adr < adl;
      bottom = adb < adt;

      c1x = right  ? a_r  : ax_e;
      c1y = bottom ? a_b  : ay_e;
      c2x = right  ? bx_e : b_r;
      c2y = bottom ? by_e : b_b;
      gx  = c1x - c2x;
      gy  = c1y - c2y;
      agx = (gx < 0) ? -gx : gx;
      agy = (gy < 0) ? -gy : gy;

      if (!hit) begin
         dir     = DIR_NONE;
         corner  = '0;
         delta_x = '0;
         delta_y = '0;
      end else begin
         if (agx > agy) begin
            dir = bottom ? DIR_DOWN : DIR_UP;
         end else begin
            dir = right ? DIR_RIGHT : DIR_LEFT;
         end
         corner  = {bottom, right};
         delta_x = agx[COORD_BITS:0];
         delta_y = agy[COORD_BITS:0];
      end
   end
endmodule

// File: src/box_box_collision_response_unit.sv
// Box-box collision response unit, top level.
// An accepted request is held in the input register, then in the result register, which drives the response.
// Throughput: one request per cycle while the response is not held; the solver is a single combinational pass.
// A held response does not stall intake until both registers are full.
// Reset (synchronous, active high) clears both valid flags; payload is not reset.
// Depends on bbcr_pkg, bbcr_req_if, bbcr_rsp_if, bbcr_solver.
module box_box_collision_response_unit
   import bbcr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   bbcr_req_if.sink    req_chan,
   bbcr_rsp_if.source  rsp_chan
);
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_BITS-2:0]        aw_ff, ah_ff, bw_ff, bh_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff;
   dir_type                      dir_ff;
   logic [CORNER_BITS-1:0]       corner_ff;
   logic [COORD_BITS:0]          dx_ff, dy_ff;

   logic                         hit_w;
   dir_type                      dir_w;
   logic [CORNER_BITS-1:0]       corner_w;
   logic [COORD_BITS:0]          dx_w, dy_w;

   logic out_free, s1_move, req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_chan.ready);

   bbcr_solver #(
      .COORD_BITS (COORD_BITS)
   ) u_solver (
      .ax      (ax_ff),
      .ay      (ay_ff),
      .aw      (aw_ff),
      .ah      (ah_ff),
      .bx      (bx_ff),
      .by      (by_ff),
      .bw      (bw_ff),
      .bh      (bh_ff),
      .hit     (hit_w),
      .dir     (dir_w),
      .corner  (corner_w),
      .delta_x (dx_w),
      .delta_y (dy_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff <= req_chan.first_x;
         ay_ff <= req_chan.first_y;
         aw_ff <= req_chan.first_width;
         ah_ff <= req_chan.first_height;
         bx_ff <= req_chan.second_x;
         by_ff <= req_chan.second_y;
         bw_ff <= req_chan.second_width;
         bh_ff <= req_chan.second_height;
      end
      if (s1_move) begin
         hit_ff    <= hit_w;
         dir_ff    <= dir_w;
         corner_ff <= corner_w;
         dx_ff     <= dx_w;
         dy_ff     <= dy_w;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.hit            = hit_ff;
   assign rsp_chan.contact_dir    = dir_ff;
   assign rsp_chan.closest_corner = corner_ff;
   assign rsp_chan.delta_x        = dx_ff;
   assign rsp_chan.delta_y        = dy_ff;
endmodule
